FILE: rtl/v3au_pkg.sv
package v3au_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_NEGATE = 4'd2,
      OP_SCALE  = 4'd3,
      OP_DIVIDE = 4'd4,
      OP_SQLEN  = 4'd5,
      OP_LENGTH = 4'd6,
      OP_NORM   = 4'd7,
      OP_EQUAL  = 4'd8
   } opcode_type;

   typedef struct packed {
      logic [3:0]                  opcode;
      logic signed [WORD_BITS-1:0] ax;
      logic signed [WORD_BITS-1:0] ay;
      logic signed [WORD_BITS-1:0] az;
      logic signed [WORD_BITS-1:0] bx;
      logic signed [WORD_BITS-1:0] by_comp;
      logic signed [WORD_BITS-1:0] bz;
      logic signed [WORD_BITS-1:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] rx;
      logic signed [WORD_BITS-1:0] ry;
      logic signed [WORD_BITS-1:0] rz;
      logic [WORD_BITS-2:0]        scalar_out;
      logic                        is_equal;
      logic                        div_zero;
   } rsp_type;

   // Side data that travels alongside the square-root chain.
   typedef struct packed {
      logic [3:0]                 op;
      logic [2:0][WORD_BITS-1:0]  a;
      logic [WORD_BITS-1:0]       s;
      logic [2:0][WORD_BITS-1:0]  vec;
      logic [WORD_BITS-2:0]       sc;
      logic                       eq;
      logic                       sum_zero;
   } sq_tag_type;

   // Side data that travels alongside the divider chain.
   typedef struct packed {
      logic [3:0]                 op;
      logic [2:0][WORD_BITS-1:0]  vec;
      logic [WORD_BITS-2:0]       sc;
      logic                       eq;
      logic                       dz;
      logic [2:0]                 neg;
   } dv_tag_type;

   // Saturates a value one bit wider than a word back to a word.
   function automatic logic [WORD_BITS-1:0] sat_word(input logic [WORD_BITS:0] v);
      logic [WORD_BITS-1:0] r;
      if (v[WORD_BITS] != v[WORD_BITS-1]) begin
         r = v[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/v3au_sqrt_cell.sv
module v3au_sqrt_cell #(
   parameter int W     = 32,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   input  logic [2*W-1:0]   up_rad,
   input  logic [W+1:0]     up_rem,
   input  logic [W-1:0]     up_root,
   input  logic [TAG_W-1:0] up_tag,
   output logic             dn_valid,
   output logic [2*W-1:0]   dn_rad,
   output logic [W+1:0]     dn_rem,
   output logic [W-1:0]     dn_root,
   output logic [TAG_W-1:0] dn_tag
);

   logic             valid_ff;
   logic [2*W-1:0]   rad_ff, rad_in;
   logic [W+1:0]     rem_ff, rem_in;
   logic [W-1:0]     root_ff, root_in;
   logic [TAG_W-1:0] tag_ff;
   logic [W+3:0]     rem2;
   logic [W+3:0]     trial;
   logic [W+3:0]     diff;
   logic             take;

   // One root digit per cell: bring down two radicand bits and try 4r+1.
   always_comb begin
      rem2    = {up_rem, up_rad[2*W-1 -: 2]};
      trial   = {2'b00, up_root, 2'b01};
      diff    = rem2 - trial;
      take    = (rem2 >= trial);
      rem_in  = take ? diff[W+1:0] : rem2[W+1:0];
      root_in = {up_root[W-2:0], take};
      rad_in  = {up_rad[2*W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      tag_ff  <= up_tag;
   end

   assign dn_valid = valid_ff;
   assign dn_rad   = rad_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_tag   = tag_ff;

endmodule

FILE: rtl/v3au_div_cell.sv
module v3au_div_cell #(
   parameter int NW    = 50,
   parameter int DW    = 34,
   parameter int TAG_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   input  logic [2:0][NW-1:0]  up_num,
   input  logic [2:0][DW-1:0]  up_rem,
   input  logic [2:0][NW-1:0]  up_quo,
   input  logic [DW-1:0]       up_den,
   input  logic [TAG_W-1:0]    up_tag,
   output logic                dn_valid,
   output logic [2:0][NW-1:0]  dn_num,
   output logic [2:0][DW-1:0]  dn_rem,
   output logic [2:0][NW-1:0]  dn_quo,
   output logic [DW-1:0]       dn_den,
   output logic [TAG_W-1:0]    dn_tag
);

   logic               valid_ff;
   logic [2:0][NW-1:0] num_ff, num_in;
   logic [2:0][DW-1:0] rem_ff, rem_in;
   logic [2:0][NW-1:0] quo_ff, quo_in;
   logic [DW-1:0]      den_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [2:0][DW:0]   rem2;
   logic [2:0][DW:0]   diff;
   logic [2:0]         take;

   // One quotient bit per cell for each of the three lanes (restoring step).
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem2[i]   = {up_rem[i], up_num[i][NW-1]};
         diff[i]   = rem2[i] - {1'b0, up_den};
         take[i]   = (rem2[i] >= {1'b0, up_den});
         rem_in[i] = take[i] ? diff[i][DW-1:0] : rem2[i][DW-1:0];
         num_in[i] = {up_num[i][NW-2:0], 1'b0};
         quo_in[i] = {up_quo[i][NW-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= up_den;
      tag_ff <= up_tag;
   end

   assign dn_valid = valid_ff;
   assign dn_num   = num_ff;
   assign dn_rem   = rem_ff;
   assign dn_quo   = quo_ff;
   assign dn_den   = den_ff;
   assign dn_tag   = tag_ff;

endmodule

FILE: rtl/vector3_arith_unit.sv
// Three-component vector unit on signed fixed-point words. A request is taken
// whenever start is high; busy is always low, so a new request may be issued
// in every clock cycle. Each request produces exactly one response, shown on
// rsp_data for a single cycle with rsp_strobe high, once the request has
// passed the input register, the multiplier stage, both chains of cells and
// the output register (words are Q16.16 by default). The receiver cannot stall
// the unit, so it must capture each response in the cycle that the strobe
// marks. The two chains are a square-root chain that forms one root bit per
// cell, and a divider chain that forms one quotient bit per cell for all three
// lanes. Every operation passes through both chains, so responses leave in
// request order.
module vector3_arith_unit #(
   parameter int FRAC_BITS = v3au_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  v3au_pkg::req_type req_data,
   output logic              rsp_strobe,
   output v3au_pkg::rsp_type rsp_data
);

   import v3au_pkg::*;

   localparam int W      = WORD_BITS;
   localparam int W2     = 2 * W;
   localparam int NW     = W + FRAC_BITS + 2;
   localparam int DW     = W + 2;
   localparam int SQ_TW  = $bits(sq_tag_type);
   localparam int DV_TW  = $bits(dv_tag_type);
   localparam int LAT    = 2 + W + NW + 1;

   localparam logic signed [W2:0] SatHi = {{(W2-W+2){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [W2:0] SatLo = ~SatHi;
   localparam logic [W2:0]        Half  = {{(W2-FRAC_BITS+1){1'b0}}, 1'b1,
                                           {(FRAC_BITS-1){1'b0}}};
   localparam logic [NW-1:0]      MinMag = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic [NW-1:0]      MaxPos = MinMag - 1'b1;

   // The unit never holds off a request.
   assign busy = 1'b0;

   // Input register.
   logic    a_valid_ff;
   req_type a_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      a_req_ff <= req_data;
   end

   // Multiplier stage: squares for the length and products for scaling.
   logic signed [2:0][W-1:0]     a_vec;
   logic signed [W2-1:0]         a_wide [3];
   logic signed [W2-1:0]         s_wide;
   logic                         b_valid_ff;
   req_type                      b_req_ff;
   logic [2:0][W2-1:0]           b_sq_ff, b_sq_in;
   logic [2:0][W2-1:0]           b_mp_ff, b_mp_in;

   assign a_vec[0] = a_req_ff.ax;
   assign a_vec[1] = a_req_ff.ay;
   assign a_vec[2] = a_req_ff.az;
   assign s_wide   = a_req_ff.scalar_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_wide[i]  = $signed(a_vec[i]);
         b_sq_in[i] = a_wide[i] * a_wide[i];
         b_mp_in[i] = a_wide[i] * s_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_req_ff <= a_req_ff;
      b_sq_ff  <= b_sq_in;
      b_mp_ff  <= b_mp_in;
   end

   // Sum of squares and all the results that need no root or quotient. These
   // feed the first cell of the root chain directly.
   logic [2:0][W-1:0]  b_a;
   logic [2:0][W-1:0]  b_b;
   logic [W2-1:0]      sum;
   logic [W2:0]        sq_round;
   logic [W2:0]        sq_shift;
   logic signed [W2:0] prod_round;
   logic signed [W2:0] prod_shift;
   sq_tag_type         c_tag;

   assign b_a[0] = b_req_ff.ax;
   assign b_a[1] = b_req_ff.ay;
   assign b_a[2] = b_req_ff.az;
   assign b_b[0] = b_req_ff.bx;
   assign b_b[1] = b_req_ff.by_comp;
   assign b_b[2] = b_req_ff.bz;

   always_comb begin
      sum      = b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
      sq_round = {1'b0, sum} + Half;
      sq_shift = sq_round >> FRAC_BITS;
      prod_round = '0;
      prod_shift = '0;

      c_tag          = '0;
      c_tag.op       = b_req_ff.opcode;
      c_tag.a        = b_a;
      c_tag.s        = b_req_ff.scalar_in;
      c_tag.sum_zero = (sum == '0);

      case (b_req_ff.opcode)
         OP_ADD: begin
            for (int i = 0; i < 3; i++) begin
               c_tag.vec[i] = sat_word({b_a[i][W-1], b_a[i]} + {b_b[i][W-1], b_b[i]});
            end
         end
         OP_SUB: begin
            for (int i = 0; i < 3; i++) begin
               c_tag.vec[i] = sat_word({b_a[i][W-1], b_a[i]} - {b_b[i][W-1], b_b[i]});
            end
         end
         OP_NEGATE: begin
            for (int i = 0; i < 3; i++) begin
               c_tag.vec[i] = sat_word((W+1)'(0) - {b_a[i][W-1], b_a[i]});
            end
         end
         OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               // Round half up, then floor by the fraction bits.
               prod_round = $signed({b_mp_ff[i][W2-1], b_mp_ff[i]}) + $signed(Half);
               prod_shift = prod_round >>> FRAC_BITS;
               if (prod_shift > SatHi) begin
                  c_tag.vec[i] = SatHi[W-1:0];
               end else if (prod_shift < SatLo) begin
                  c_tag.vec[i] = SatLo[W-1:0];
               end else begin
                  c_tag.vec[i] = prod_shift[W-1:0];
               end
            end
         end
         OP_SQLEN: begin
            c_tag.sc = (sq_shift > {{(W2-W+2){1'b0}}, {(W-1){1'b1}}})
                     ? {(W-1){1'b1}} : sq_shift[W-2:0];
         end
         OP_EQUAL: begin
            c_tag.eq = (b_a[0] == b_b[0]) && (b_a[1] == b_b[1]) && (b_a[2] == b_b[2]);
         end
         default: begin
         end
      endcase
   end

   // Square-root chain: one root bit per cell.
   logic             sq_valid [W+1];
   logic [W2-1:0]    sq_rad   [W+1];
   logic [W+1:0]     sq_rem   [W+1];
   logic [W-1:0]     sq_root  [W+1];
   logic [SQ_TW-1:0] sq_tag   [W+1];

   assign sq_valid[0] = b_valid_ff;
   assign sq_rad[0]   = sum;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_tag[0]   = c_tag;

   for (genvar k = 0; k < W; k++) begin : g_sqrt
      v3au_sqrt_cell #(
         .W     (W),
         .TAG_W (SQ_TW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (sq_valid[k]),
         .up_rad   (sq_rad[k]),
         .up_rem   (sq_rem[k]),
         .up_root  (sq_root[k]),
         .up_tag   (sq_tag[k]),
         .dn_valid (sq_valid[k+1]),
         .dn_rad   (sq_rad[k+1]),
         .dn_rem   (sq_rem[k+1]),
         .dn_root  (sq_root[k+1]),
         .dn_tag   (sq_tag[k+1])
      );
   end

   // Divider set-up: round the root to nearest, pick the divisor and form the
   // numerators 2|a|*2^F + d over the denominator 2d, which rounds halves away
   // from zero.
   sq_tag_type          r_tag;
   dv_tag_type          d_tag;
   logic [W:0]          len;
   logic [W:0]          s_ext;
   logic [W:0]          dmag;
   logic [W:0]          amag;
   logic [DW-1:0]       den;
   logic [2:0][NW-1:0]  num0;

   assign r_tag = sq_tag[W];

   always_comb begin
      len   = {1'b0, sq_root[W]} + (W+1)'(sq_rem[W] > {2'b00, sq_root[W]});
      s_ext = {r_tag.s[W-1], r_tag.s};
      dmag  = (r_tag.op == OP_NORM) ? len : (s_ext[W] ? ((W+1)'(0) - s_ext) : s_ext);
      den   = {dmag, 1'b0};

      d_tag     = '0;
      d_tag.op  = r_tag.op;
      d_tag.vec = r_tag.vec;
      d_tag.sc  = r_tag.sc;
      d_tag.eq  = r_tag.eq;
      if (r_tag.op == OP_LENGTH) begin
         d_tag.sc = (len > {2'b00, {(W-1){1'b1}}}) ? {(W-1){1'b1}} : len[W-2:0];
      end
      d_tag.dz = ((r_tag.op == OP_DIVIDE) && (r_tag.s == '0))
              || ((r_tag.op == OP_NORM) && r_tag.sum_zero);

      for (int i = 0; i < 3; i++) begin
         amag = r_tag.a[i][W-1] ? ((W+1)'(0) - {1'b1, r_tag.a[i]}) : {1'b0, r_tag.a[i]};
         d_tag.neg[i] = r_tag.a[i][W-1] ^ ((r_tag.op == OP_DIVIDE) && r_tag.s[W-1]);
         num0[i] = ({{(NW-W-1){1'b0}}, amag} << (FRAC_BITS + 1))
                 + {{(NW-W-1){1'b0}}, dmag};
      end
   end

   // Divider chain: one quotient bit per cell, three lanes abreast.
   logic               dv_valid [NW+1];
   logic [2:0][NW-1:0] dv_num   [NW+1];
   logic [2:0][DW-1:0] dv_rem   [NW+1];
   logic [2:0][NW-1:0] dv_quo   [NW+1];
   logic [DW-1:0]      dv_den   [NW+1];
   logic [DV_TW-1:0]   dv_tag   [NW+1];

   assign dv_valid[0] = sq_valid[W];
   assign dv_num[0]   = num0;
   assign dv_rem[0]   = '0;
   assign dv_quo[0]   = '0;
   assign dv_den[0]   = den;
   assign dv_tag[0]   = d_tag;

   for (genvar k = 0; k < NW; k++) begin : g_div
      v3au_div_cell #(
         .NW    (NW),
         .DW    (DW),
         .TAG_W (DV_TW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (dv_valid[k]),
         .up_num   (dv_num[k]),
         .up_rem   (dv_rem[k]),
         .up_quo   (dv_quo[k]),
         .up_den   (dv_den[k]),
         .up_tag   (dv_tag[k]),
         .dn_valid (dv_valid[k+1]),
         .dn_num   (dv_num[k+1]),
         .dn_rem   (dv_rem[k+1]),
         .dn_quo   (dv_quo[k+1]),
         .dn_den   (dv_den[k+1]),
         .dn_tag   (dv_tag[k+1])
      );
   end

   // Output stage: apply the sign to each quotient, saturate, and choose
   // between the quotient and the vector formed earlier.
   dv_tag_type        f_tag;
   logic [2:0][W-1:0] f_vec;
   logic [NW-1:0]     q;
   logic              use_quo;
   logic              strobe_ff;
   rsp_type           rsp_ff, rsp_in;

   assign f_tag   = dv_tag[NW];
   assign use_quo = ((f_tag.op == OP_DIVIDE) || (f_tag.op == OP_NORM)) && !f_tag.dz;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q = dv_quo[NW][i];
         if (!use_quo) begin
            f_vec[i] = f_tag.vec[i];
         end else if (f_tag.neg[i]) begin
            f_vec[i] = (q > MinMag) ? MinMag[W-1:0] : W'(0) - q[W-1:0];
         end else begin
            f_vec[i] = (q > MaxPos) ? MaxPos[W-1:0] : q[W-1:0];
         end
      end
      rsp_in.rx         = f_vec[0];
      rsp_in.ry         = f_vec[1];
      rsp_in.rz         = f_vec[2];
      rsp_in.scalar_out = f_tag.sc;
      rsp_in.is_equal   = f_tag.eq;
      rsp_in.div_zero   = f_tag.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_valid[NW];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // A response appears exactly one pipeline latency after its request.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("response without a request one latency earlier");

   // A zero divisor or zero vector yields the zero vector and no scalar.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.div_zero) |->
         (rsp_data.rx == '0) && (rsp_data.ry == '0) && (rsp_data.rz == '0)
         && (rsp_data.scalar_out == '0))
      else $error("divide-by-zero response carries a non-zero result");

   // An equal result carries a zero x component, a zero scalar and no divide-by-zero flag.
   a_eq_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.is_equal) |->
         (rsp_data.rx == '0) && (rsp_data.scalar_out == '0) && !rsp_data.div_zero)
      else $error("equality response carries other results");

endmodule
